@@ sv/ic3_pkg.sv @@
// ============================================================================
// ic3_pkg
// Shared constants and types for the 3x3 convolution block.
// ============================================================================
package ic3_pkg;

    localparam int unsigned PIX_W   = 24;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned REG_W   = 48;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DIM_W   = 11;
    localparam int unsigned HEIGHT_LIMIT = 1024;

    localparam logic [ADDR_W-1:0] REG_COEF_TOP = 3'd0;
    localparam logic [ADDR_W-1:0] REG_COEF_MID = 3'd1;
    localparam logic [ADDR_W-1:0] REG_COEF_BOT = 3'd2;
    localparam logic [ADDR_W-1:0] REG_WIDTH    = 3'd3;
    localparam logic [ADDR_W-1:0] REG_HEIGHT   = 3'd4;
    localparam logic [ADDR_W-1:0] REG_MODE     = 3'd5;

    typedef logic [PIX_W-1:0] t_pix;

    // Window tap request handed from the line-buffer front end to the
    // arithmetic back end.
    typedef struct packed {
        logic       valid;
        logic       last;
        logic       rgb;
        t_pix [8:0] taps;   // index row*3+col of the (already clamped) kernel view
    } t_win;

endpackage

@@ sv/ic3_if.sv @@
// ============================================================================
// ic3_if
// Valid/ready stream channel carrying a payload of type T.
// ============================================================================
interface ic3_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/ic3_in_t.sv @@
// ============================================================================
// ic3_in_t
// Stream item types of the convolution block.
// ============================================================================
package ic3_io_pkg;
    typedef struct packed {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } t_out_item;
endpackage

@@ sv/ic3_div.sv @@
// ============================================================================
// ic3_div
// Sequential signed divider: one quotient bit per cycle, truncating.
// ============================================================================
module ic3_div #(
    parameter int unsigned NUM_W = 32,
    parameter int unsigned DEN_W = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quo
);
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo, n_quo;
    logic [NUM_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [NUM_W:0]   w_try;

    assign w_try = {r_rem[NUM_W-1:0], r_quo[NUM_W-1]} - {{(NUM_W+1-DEN_W){1'b0}}, r_den};

    always_comb begin
        n_rem = {r_rem[NUM_W-1:0], r_quo[NUM_W-1]};
        n_quo = {r_quo[NUM_W-2:0], 1'b0};
        if (!w_try[NUM_W]) begin
            n_rem = w_try;
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num[NUM_W-1] ? NUM_W'(-i_num) : i_num;
            r_den <= i_den[DEN_W-1] ? DEN_W'(-i_den) : i_den;
            r_neg <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? NUM_W'(-r_quo) : r_quo;
endmodule

@@ sv/ic3_core.sv @@
// ============================================================================
// ic3_core
// Kernel arithmetic: nine products per channel, kernel sum, divide, clamp.
// ============================================================================
module ic3_core #(
    parameter int unsigned COEF_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ic3_pkg::t_win             i_win,
    input  logic [ic3_pkg::REG_W-1:0] i_coef_top,
    input  logic [ic3_pkg::REG_W-1:0] i_coef_mid,
    input  logic [ic3_pkg::REG_W-1:0] i_coef_bot,
    output logic                      o_valid,
    output logic [7:0]                o_red,
    output logic [7:0]                o_green,
    output logic [7:0]                o_blue,
    output logic                      o_last
);
    localparam int unsigned PROD_W = COEF_BITS + 9;
    localparam int unsigned ACC_W  = PROD_W + 4;
    localparam int unsigned SUM_W  = COEF_BITS + 4;

    logic signed [COEF_BITS-1:0] w_k [9];
    logic signed [SUM_W-1:0]     w_ksum;
    logic [ic3_pkg::REG_W-1:0]   w_row [3];

    assign w_row[0] = i_coef_top;
    assign w_row[1] = i_coef_mid;
    assign w_row[2] = i_coef_bot;

    // Field order within a row register: centre low, left middle, right high.
    always_comb begin
        w_ksum = '0;
        for (int r = 0; r < 3; r++) begin
            w_k[r*3+0] = w_row[r][16 +: COEF_BITS];
            w_k[r*3+1] = w_row[r][0  +: COEF_BITS];
            w_k[r*3+2] = w_row[r][32 +: COEF_BITS];
        end
        for (int i = 0; i < 9; i++) begin
            w_ksum = w_ksum + SUM_W'(w_k[i]);
        end
    end

    // Stage 1: products. Tap (r,c) meets flipped coefficient (2-r,2-c).
    logic signed [PROD_W-1:0] r_prod [3][9];
    logic                     r_s1_valid, r_s1_last, r_s1_rgb;
    logic signed [SUM_W-1:0]  r_ksum;

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 9; i++) begin
                r_prod[ch][i] <= $signed({1'b0, i_win.taps[i][ch*8 +: 8]}) * w_k[8-i];
            end
        end
        r_ksum    <= w_ksum;
        r_s1_last <= i_win.last;
        r_s1_rgb  <= i_win.rgb;
    end

    // Stage 2: accumulate.
    logic signed [ACC_W-1:0] r_acc [3];
    logic                    r_s2_valid, r_s2_last, r_s2_rgb;
    logic signed [SUM_W-1:0] r_den;

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 3; ch++) begin
            logic signed [ACC_W-1:0] s;
            s = '0;
            for (int i = 0; i < 9; i++) begin
                s = s + ACC_W'(r_prod[ch][i]);
            end
            r_acc[ch] <= s;
        end
        r_den     <= (r_ksum != '0) ? r_ksum : SUM_W'(256);
        r_s2_last <= r_s1_last;
        r_s2_rgb  <= r_s1_rgb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_win.valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage 3: three serial dividers.
    logic                    w_done [3];
    logic signed [ACC_W-1:0] w_quo  [3];
    logic                    r_last, r_rgb;

    for (genvar ch = 0; ch < 3; ch++) begin : g_div
        ic3_div #(.NUM_W(ACC_W), .DEN_W(SUM_W)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_s2_valid),
            .i_num   (r_acc[ch]),
            .i_den   (r_den),
            .o_done  (w_done[ch]),
            .o_quo   (w_quo[ch])
        );
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_last <= r_s2_last;
            r_rgb  <= r_s2_rgb;
        end
    end

    function automatic logic [7:0] sat(input logic signed [ACC_W-1:0] v);
        if (v < 0) begin
            return 8'd0;
        end else if (v > ACC_W'(255)) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    assign o_valid = w_done[0];
    assign o_red   = sat(w_quo[0]);
    assign o_green = r_rgb ? sat(w_quo[1]) : 8'd0;
    assign o_blue  = r_rgb ? sat(w_quo[2]) : 8'd0;
    assign o_last  = r_last;

`ifndef ASSERT_OFF
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done[0] |-> (w_done[1] && w_done[2]))
        else $error("dividers out of step");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |=> !r_s2_valid)
        else $error("second item entered while dividing");
    a_grey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_rgb) |-> (o_green == 8'd0 && o_blue == 8'd0))
        else $error("grey mode colour channels not zero");
`endif
endmodule

@@ sv/ic3_lines.sv @@
// ============================================================================
// ic3_lines
// Line stores, window registers and raster position tracking.
// ============================================================================
module ic3_lines #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_restart,
    input  logic                      i_go,
    input  logic                      i_kind,
    input  ic3_pkg::t_pix             i_pix,
    input  logic [ic3_pkg::DIM_W-1:0] i_width,
    input  logic [ic3_pkg::DIM_W-1:0] i_height,
    input  logic                      i_rgb,
    output logic                      o_drop,
    output ic3_pkg::t_win             o_win
);
    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned CW = AW + 1;

    ic3_pkg::t_pix r_mem_a [MAX_WIDTH];
    ic3_pkg::t_pix r_mem_b [MAX_WIDTH];
    ic3_pkg::t_pix r_rd_a, r_rd_b;
    ic3_pkg::t_pix r_win [9];
    ic3_pkg::t_pix r_pix;

    logic [CW-1:0]  w_w;
    logic [10:0]    w_h;
    logic [CW-1:0]  r_col, r_c1;
    logic [10:0]    r_row, r_r1;
    logic           r_ph;
    logic [AW-1:0]  w_addr;
    logic           w_done_in;
    logic           w_frame_done;

    // Effective geometry.
    always_comb begin
        w_w = (i_width == '0) ? CW'(1)
            : (32'(i_width) > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(i_width);
        w_h = (i_height == '0) ? 11'd1
            : (i_height > 11'(ic3_pkg::HEIGHT_LIMIT)) ? 11'(ic3_pkg::HEIGHT_LIMIT)
            : i_height;
    end

    assign w_done_in = (r_row >= w_h);
    assign o_drop    = i_kind && !w_done_in;
    assign w_addr    = AW'((r_col >= w_w) ? '0 : r_col);

    // The frame's last position leaves on the item at column 0 of row h+1;
    // the position counters start over once that item has been taken.
    assign w_frame_done = r_ph && (r_c1 == '0) && (r_r1 == w_h + 11'd1);

    // Phase 0: read stores. Phase 1: write back, shift window, emit.
    always_ff @(posedge i_clk) begin
        if (i_go && !o_drop) begin
            r_rd_a <= r_mem_a[w_addr];
            r_rd_b <= r_mem_b[w_addr];
        end
        if (r_ph) begin
            r_mem_a[r_c1[AW-1:0]] <= r_pix;
            r_mem_b[r_c1[AW-1:0]] <= r_rd_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= 1'b0;
            for (int i = 0; i < 9; i++) r_win[i] <= '0;
        end else begin
            r_ph <= i_go && !o_drop && !i_restart;
            if (r_ph) begin
                for (int i = 0; i < 6; i++) r_win[i] <= r_win[i+3];
                r_win[6] <= r_rd_b;
                r_win[7] <= r_rd_a;
                r_win[8] <= r_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart || w_frame_done) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_go && !o_drop) begin
            r_pix <= (i_kind || w_done_in) ? '0
                   : i_rgb ? i_pix : {16'd0, i_pix[7:0]};
            r_c1  <= CW'(w_addr);
            r_r1  <= r_row;
            if (CW'(w_addr) + 1'b1 >= w_w) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= CW'(w_addr) + 1'b1;
            end
        end
    end

    // Output request from the updated window (visible in the cycle after phase 1).
    logic          r_emit;
    logic [CW-1:0] r_ec;
    logic [10:0]   r_er;
    logic          r_er_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
        end else begin
            r_emit <= r_ph && (r_r1 >= 11'd2 || (r_r1 == 11'd1 && r_c1 >= CW'(1)));
        end
        if (r_ph) begin
            r_ec     <= (r_c1 >= CW'(1)) ? r_c1 - 1'b1 : w_w - 1'b1;
            r_er     <= (r_c1 >= CW'(1)) ? r_r1 - 11'd1 : r_r1 - 11'd2;
            r_er_rgb <= i_rgb;
        end
    end

    logic [1:0] w_cs [3];
    logic [1:0] w_rs [3];

    always_comb begin
        w_cs[0] = (r_ec >= CW'(1)) ? 2'd0 : 2'd1;
        w_cs[1] = 2'd1;
        w_cs[2] = (r_ec + 1'b1 < w_w) ? 2'd2 : 2'd1;
        w_rs[0] = (r_er >= 11'd1) ? 2'd0 : 2'd1;
        w_rs[1] = 2'd1;
        w_rs[2] = (r_er + 11'd1 < w_h) ? 2'd2 : 2'd1;
        o_win.valid = r_emit;
        o_win.rgb   = r_er_rgb;
        o_win.last  = (r_er + 11'd1 == w_h) && (r_ec + 1'b1 == w_w);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                o_win.taps[i*3+j] = r_win[w_cs[j]*3 + w_rs[i]];
            end
        end
    end

`ifndef ASSERT_OFF
    a_ph_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph |=> !r_ph)
        else $error("line store write phase repeated");
    a_emit_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> $past(r_ph))
        else $error("window emitted without update");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(MAX_WIDTH))
        else $error("column out of range");
`endif
endmodule

@@ sv/image_convolution_3x3_top.sv @@
// ============================================================================
// image_convolution_3x3_top
// 3x3 convolution over a raster pixel stream, grey or RGB.
// ============================================================================
// Usage:
// Pixels enter on s_in in raster order (kind 0); drain ticks (kind 1) push
// out the last W+1 positions after the frame's final pixel. Each transfer
// on s_in yields at most one filtered pixel on m_out, for the position
// W+1 items earlier, with frame_end set on the frame's last position.
// Registers are written on the plain port (i_cfg_we/addr/data) while idle;
// a geometry or mode write restarts the frame, and so does frame_end.
// Sequencing: one item is worked at a time. The line stores are read and
// then written back, the window is handed over after that, the arithmetic
// registers the products and then their sum, and a bit-serial divider
// gives one quotient bit per cycle over the COEF_BITS+13 accumulator bits.
// Items that give no result end once it is known that no window was
// emitted, and an early drain tick is dropped while the block stays idle.
// Reset clears counters and window and loads register defaults; line
// stores stay unknown and are never read before written at a visible tap.
// A stalled receiver holds the result in the output register; the block
// then takes no new item until that transfer completes.
// ============================================================================
module image_convolution_3x3_top #(
    parameter int unsigned MAX_WIDTH = 1024,
    parameter int unsigned COEF_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ic3_pkg::ADDR_W-1:0] i_cfg_addr,
    input  logic [ic3_pkg::REG_W-1:0] i_cfg_data,
    ic3_if.sink                       s_in,
    ic3_if.source                     m_out
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [ic3_pkg::REG_W-1:0] r_coef_top, r_coef_mid, r_coef_bot;
    logic [ic3_pkg::DIM_W-1:0] r_width, r_height;
    logic                      r_rgb;
    logic                      w_restart;

    assign w_restart = i_cfg_we && (i_cfg_addr == ic3_pkg::REG_WIDTH
                     || i_cfg_addr == ic3_pkg::REG_HEIGHT
                     || i_cfg_addr == ic3_pkg::REG_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top <= '0;
            r_coef_mid <= ic3_pkg::REG_W'(256);
            r_coef_bot <= '0;
            r_width    <= ic3_pkg::DIM_W'(1024);
            r_height   <= ic3_pkg::DIM_W'(1024);
            r_rgb      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ic3_pkg::REG_COEF_TOP: r_coef_top <= i_cfg_data;
                ic3_pkg::REG_COEF_MID: r_coef_mid <= i_cfg_data;
                ic3_pkg::REG_COEF_BOT: r_coef_bot <= i_cfg_data;
                ic3_pkg::REG_WIDTH:    r_width    <= i_cfg_data[ic3_pkg::DIM_W-1:0];
                ic3_pkg::REG_HEIGHT:   r_height   <= i_cfg_data[ic3_pkg::DIM_W-1:0];
                ic3_pkg::REG_MODE:     r_rgb      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [1:0]    r_state;
    logic          w_go, w_drop;
    ic3_pkg::t_win w_win;
    logic          w_valid, w_last;
    logic [7:0]    w_r, w_g, w_b;
    logic [4:0]    r_idle_cnt;

    assign s_in.ready = (r_state == ST_IDLE);
    assign w_go       = s_in.valid && s_in.ready;

    ic3_lines #(.MAX_WIDTH(MAX_WIDTH)) u_lines (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_restart),
        .i_go      (w_go),
        .i_kind    (s_in.data.kind),
        .i_pix     ({s_in.data.blue, s_in.data.green, s_in.data.red}),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_rgb     (r_rgb),
        .o_drop    (w_drop),
        .o_win     (w_win)
    );

    ic3_core #(.COEF_BITS(COEF_BITS)) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_win      (w_win),
        .i_coef_top (r_coef_top),
        .i_coef_mid (r_coef_mid),
        .i_coef_bot (r_coef_bot),
        .o_valid    (w_valid),
        .o_red      (w_r),
        .o_green    (w_g),
        .o_blue     (w_b),
        .o_last     (w_last)
    );

    // Result register and item sequencing. After an accepted item we wait
    // until it is known whether a window was emitted, then for the result.
    logic r_out_valid;
    logic r_waiting;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_waiting   <= 1'b0;
            r_idle_cnt  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_go && !w_drop) begin
                        r_state    <= ST_RUN;
                        r_idle_cnt <= '0;
                        r_waiting  <= 1'b0;
                    end
                end
                ST_RUN: begin
                    r_idle_cnt <= r_idle_cnt + 1'b1;
                    if (w_win.valid) begin
                        r_waiting <= 1'b1;
                    end
                    if (w_valid) begin
                        r_out_valid   <= 1'b1;
                        m_out.data    <= '{out_red: w_r, out_green: w_g,
                                           out_blue: w_b, frame_end: w_last};
                        r_state       <= ST_OUT;
                    end else if (r_idle_cnt == 5'd1 && !w_win.valid && !r_waiting) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (m_out.ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // The line unit starts its position counters over by itself once the
    // frame's last position has been emitted.
    assign m_out.valid = r_out_valid;

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> !s_in.ready)
        else $error("input accepted while result pending");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && m_out.ready) |=> !m_out.valid)
        else $error("result repeated");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> $stable(m_out.data))
        else $error("stalled result changed");
`endif
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the 3x3 raster convolution block: a queue-fed
// driver, a stalling receiver and an item-level pixel predictor.
// ============================================================================
module tb_top;

    localparam int unsigned MAX_WIDTH   = 1024;
    localparam int unsigned COEF_BITS   = 16;
    // The block is taken as quiet this many cycles after the last result.
    localparam int unsigned SETTLE      = 80;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    // After this many cycles the receiver refuses every transfer for a
    // while, so that the output register fills and the input side backs up.
    localparam int unsigned HOLD_START  = 4000;
    localparam int unsigned HOLD_LEN    = 600;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [ic3_pkg::ADDR_W-1:0] i_cfg_addr;
    logic [ic3_pkg::REG_W-1:0]  i_cfg_data;

    ic3_if #(.T(ic3_io_pkg::t_in_item))  pix_in ();
    ic3_if #(.T(ic3_io_pkg::t_out_item)) pix_out ();

    image_convolution_3x3_top #(
        .MAX_WIDTH(MAX_WIDTH),
        .COEF_BITS(COEF_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data),
        .s_in      (pix_in.sink),
        .m_out     (pix_out.source)
    );

    // ------------------------------------------------------------------------
    // Predictor state. These mirror the block's registers, line stores and
    // window so that each accepted item gives its filtered pixel, if any.
    // ------------------------------------------------------------------------
    logic [ic3_pkg::REG_W-1:0] coef_rows [3];
    logic [ic3_pkg::DIM_W-1:0] width_reg;
    logic [ic3_pkg::DIM_W-1:0] height_reg;
    logic                      rgb_reg;
    ic3_pkg::t_pix             row_store_a [MAX_WIDTH];
    ic3_pkg::t_pix             row_store_b [MAX_WIDTH];
    ic3_pkg::t_pix             window [9];     // index col*3+row, col 0 is the oldest
    int unsigned               next_col;
    int unsigned               next_row;

    ic3_io_pkg::t_in_item  stream_items [$];      // items still to be offered
    ic3_io_pkg::t_out_item pixels_due [$];        // filtered pixels still to arrive
    int unsigned error_count;
    int unsigned cycle_count;

    function automatic int unsigned active_width();
        int unsigned w;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = height_reg;
        if (h < 1) h = 1;
        if (h > ic3_pkg::HEIGHT_LIMIT) h = ic3_pkg::HEIGHT_LIMIT;
        return h;
    endfunction

    // Kernel coefficient at row kr and column kc, both counted from the top
    // left. The centre column sits in the low field of each row register.
    function automatic longint kernel_tap(int unsigned kr, int unsigned kc);
        int unsigned slot;
        logic [15:0] field;
        slot  = (kc == 1) ? 0 : ((kc == 0) ? 1 : 2);
        field = coef_rows[kr][16*slot +: 16];
        return longint'($signed(field));
    endfunction

    function automatic void restart_frame();
        next_col = 0;
        next_row = 0;
    endfunction

    function automatic void apply_register(logic [ic3_pkg::ADDR_W-1:0] idx,
                                           logic [ic3_pkg::REG_W-1:0] val);
        case (idx)
            ic3_pkg::REG_COEF_TOP: coef_rows[0] = val;
            ic3_pkg::REG_COEF_MID: coef_rows[1] = val;
            ic3_pkg::REG_COEF_BOT: coef_rows[2] = val;
            ic3_pkg::REG_WIDTH: begin
                width_reg = val[ic3_pkg::DIM_W-1:0];
                restart_frame();
            end
            ic3_pkg::REG_HEIGHT: begin
                height_reg = val[ic3_pkg::DIM_W-1:0];
                restart_frame();
            end
            ic3_pkg::REG_MODE: begin
                rgb_reg = val[0];
                restart_frame();
            end
            default: ;
        endcase
    endfunction

    // Advances the predictor by one accepted item; returns 1 when the item
    // releases a filtered pixel, which is then left in res.
    function automatic bit convolve_item(ic3_io_pkg::t_in_item it,
                                         output ic3_io_pkg::t_out_item res);
        int unsigned   w, h, col, row, r, c, ch, i, j;
        int unsigned   col_pick [3];
        int unsigned   row_pick [3];
        bit            frame_in;
        ic3_pkg::t_pix pix, above, above2;
        longint        ksum, acc, quot;
        logic [7:0]    chan [3];
        w = active_width();
        h = active_height();
        frame_in = next_row >= h;
        res = '0;
        // A drain tick before the frame's last pixel is simply dropped.
        if (it.kind && !frame_in) return 0;
        pix = '0;
        // A pixel after the frame's last one only pushes the pipeline on.
        if (!it.kind && !frame_in) begin
            pix[7:0] = it.red;
            if (rgb_reg) pix[23:8] = {it.blue, it.green};
        end
        if (next_col >= w) next_col = 0;
        col = next_col;
        row = next_row;
        above  = row_store_a[col];
        above2 = row_store_b[col];
        row_store_b[col] = above;
        row_store_a[col] = pix;
        for (i = 0; i < 6; i++) window[i] = window[i+3];
        window[6] = above2;
        window[7] = above;
        window[8] = pix;
        if (col + 1 >= w) begin
            next_col = 0;
            next_row = row + 1;
        end else begin
            next_col = col + 1;
        end
        if (!(row >= 2 || (row == 1 && col >= 1))) return 0;
        if (col >= 1) begin
            r = row - 1;
            c = col - 1;
        end else begin
            r = row - 2;
            c = w - 1;
        end
        // Neighbours past an edge repeat the edge pixel.
        col_pick[0] = (c >= 1) ? 0 : 1;
        col_pick[1] = 1;
        col_pick[2] = (c + 1 < w) ? 2 : 1;
        row_pick[0] = (r >= 1) ? 0 : 1;
        row_pick[1] = 1;
        row_pick[2] = (r + 1 < h) ? 2 : 1;
        ksum = 0;
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
                ksum += kernel_tap(i, j);
        for (ch = 0; ch < 3; ch++) begin
            chan[ch] = '0;
            if (ch == 0 || rgb_reg) begin
                acc = 0;
                // The kernel is flipped in both directions.
                for (i = 0; i < 3; i++)
                    for (j = 0; j < 3; j++)
                        acc += longint'(window[col_pick[j]*3 + row_pick[i]][8*ch +: 8])
                               * kernel_tap(2 - i, 2 - j);
                quot = (ksum != 0) ? acc / ksum : acc / 256;
                if (quot < 0) quot = 0;
                if (quot > 255) quot = 255;
                chan[ch] = quot[7:0];
            end
        end
        res.out_red   = chan[0];
        res.out_green = chan[1];
        res.out_blue  = chan[2];
        res.frame_end = (r + 1 == h) && (c + 1 == w);
        if (res.frame_end) restart_frame();
        return 1;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, and the timeout guard that ends a hung run.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver. It offers the head of the item queue in bursts of random
    // length separated by random gaps. An offered item stays on the bus
    // until its transfer completes, and each transfer feeds the predictor.
    // ------------------------------------------------------------------------
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge i_clk) begin
        ic3_io_pkg::t_out_item res;
        bit                    offer;
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (pix_in.valid && pix_in.ready) begin
                if (convolve_item(pix_in.data, res)) pixels_due.push_back(res);
                void'(stream_items.pop_front());
            end
            offer = 1'b0;
            if (pix_in.valid && !pix_in.ready) begin
                offer = 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (stream_items.size() > 0) begin
                offer = 1'b1;
                if (burst_left == 0) begin
                    // Bursts are sometimes long, so that stretches without
                    // any idling occur as well.
                    burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                               : $urandom_range(1, 8);
                    gap_left <= $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
            pix_in.valid <= offer && (stream_items.size() > 0);
            if (stream_items.size() > 0) pix_in.data <= stream_items[0];
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Its ready follows a stall pattern that changes at random
    // intervals, and a separate counter forces one long hold-off that
    // starts while the sender still has items to offer.
    // ------------------------------------------------------------------------
    logic        long_hold;
    logic        hold_used;
    int unsigned hold_count;
    int unsigned hold_left;
    int unsigned pattern;
    int unsigned pattern_left;
    int unsigned stall_phase;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_count <= 0;
            hold_left <= 0;
            hold_used <= 1'b0;
            long_hold <= 1'b0;
        end else begin
            hold_count <= hold_count + 1;
            if (long_hold) begin
                if (hold_left == 0) long_hold <= 1'b0;
                else hold_left <= hold_left - 1;
            end else if (!hold_used && hold_count >= HOLD_START
                         && stream_items.size() > 1) begin
                long_hold <= 1'b1;
                hold_used <= 1'b1;
                hold_left <= HOLD_LEN;
            end
        end
    end

    always @(posedge i_clk) begin
        bit rdy;
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
            pattern <= 0;
            pattern_left <= 0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (pattern_left == 0) begin
                pattern <= $urandom_range(0, 3);
                pattern_left <= $urandom_range(50, 400);
            end else begin
                pattern_left <= pattern_left - 1;
            end
            case (pattern)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 3) != 0);
                2: rdy = stall_phase[0];
                default: rdy = ($urandom_range(0, 7) == 0);
            endcase
            pix_out.ready <= rdy && !long_hold;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every transfer on the output is checked field by field
    // against the oldest predicted pixel.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        ic3_io_pkg::t_out_item want;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            if (pixels_due.size() == 0) begin
                $display("%0t: unexpected output pixel, expected none, actual %h",
                         $realtime, pix_out.data);
                error_count++;
            end else begin
                want = pixels_due.pop_front();
                if (pix_out.data.out_red !== want.out_red) begin
                    $display("%0t: out_red expected %0d actual %0d",
                             $realtime, want.out_red, pix_out.data.out_red);
                    error_count++;
                end
                if (pix_out.data.out_green !== want.out_green) begin
                    $display("%0t: out_green expected %0d actual %0d",
                             $realtime, want.out_green, pix_out.data.out_green);
                    error_count++;
                end
                if (pix_out.data.out_blue !== want.out_blue) begin
                    $display("%0t: out_blue expected %0d actual %0d",
                             $realtime, want.out_blue, pix_out.data.out_blue);
                    error_count++;
                end
                if (pix_out.data.frame_end !== want.frame_end) begin
                    $display("%0t: frame_end expected %0d actual %0d",
                             $realtime, want.frame_end, pix_out.data.frame_end);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequencing.
    // ------------------------------------------------------------------------

    // Waits until every item has been offered and accepted and every
    // predicted pixel has arrived, then lets the block settle.
    task automatic wait_idle();
        while (stream_items.size() > 0 || pix_in.valid || pixels_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ic3_pkg::ADDR_W-1:0] idx,
                             input logic [ic3_pkg::REG_W-1:0] val);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        apply_register(idx, val);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic ic3_io_pkg::t_in_item random_pixel();
        ic3_io_pkg::t_in_item it;
        logic [31:0]          raw;
        raw = $urandom;
        it = raw[$bits(ic3_io_pkg::t_in_item)-1:0];
        it.kind = 1'b0;
        return it;
    endfunction

    function automatic ic3_io_pkg::t_in_item drain_tick();
        ic3_io_pkg::t_in_item it;
        logic [31:0]          raw;
        raw = $urandom;
        it = raw[$bits(ic3_io_pkg::t_in_item)-1:0];
        it.kind = 1'b1;
        return it;
    endfunction

    // Queues pix_count pixels of a frame and, if they fill it, enough drain
    // ticks to flush it. With noise set, early drain ticks fall between
    // pixels, surplus pixels replace some drains, and a stray drain may follow.
    task automatic queue_frame(input int unsigned w, input int unsigned h,
                               input int unsigned pix_count, input bit noise,
                               inout int unsigned queued);
        int unsigned k;
        for (k = 0; k < pix_count; k++) begin
            if (noise && $urandom_range(0, 19) == 0) begin
                stream_items.push_back(drain_tick());
                queued++;
            end
            stream_items.push_back(random_pixel());
            queued++;
        end
        if (pix_count == w * h) begin
            for (k = 0; k < w + 1; k++) begin
                if (noise && $urandom_range(0, 7) == 0) stream_items.push_back(random_pixel());
                else stream_items.push_back(drain_tick());
                queued++;
            end
            if (noise && $urandom_range(0, 5) == 0) begin
                stream_items.push_back(drain_tick());
                queued++;
            end
        end
    endtask

    function automatic logic [15:0] small_coef();
        int c;
        c = $urandom_range(0, 1024);
        c = c - 512;
        return 16'(c);
    endfunction

    function automatic logic [ic3_pkg::REG_W-1:0] pick_row(int unsigned style);
        logic [ic3_pkg::REG_W-1:0] v;
        case (style)
            0: v = ic3_pkg::REG_W'({$urandom, $urandom});
            1: v = {small_coef(), small_coef(), small_coef()};
            default: v = {($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF),
                          ($urandom_range(0, 1) ? 16'h8000 : 16'h0000),
                          ($urandom_range(0, 1) ? 16'h7FFF : 16'hFFFF)};
        endcase
        return v;
    endfunction

    task automatic set_kernel();
        logic [15:0] a, b, c;
        int unsigned style;
        style = $urandom_range(0, 5);
        if (style == 5) begin
            // Top and bottom rows cancel and the middle row is empty, so the
            // coefficient sum is zero and the fixed divisor applies.
            a = small_coef();
            b = small_coef();
            c = small_coef();
            write_reg(ic3_pkg::REG_COEF_TOP, {a, b, c});
            write_reg(ic3_pkg::REG_COEF_MID, '0);
            write_reg(ic3_pkg::REG_COEF_BOT, {-a, -b, -c});
        end else begin
            if (style > 2) style = 1;
            write_reg(ic3_pkg::REG_COEF_TOP, pick_row(style));
            write_reg(ic3_pkg::REG_COEF_MID, pick_row(style));
            write_reg(ic3_pkg::REG_COEF_BOT, pick_row(style));
        end
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h, input bit rgb);
        write_reg(ic3_pkg::REG_WIDTH, ic3_pkg::REG_W'(w));
        write_reg(ic3_pkg::REG_HEIGHT, ic3_pkg::REG_W'(h));
        write_reg(ic3_pkg::REG_MODE, ic3_pkg::REG_W'(rgb));
    endtask

    initial begin
        int unsigned queued;
        int unsigned w, h;
        queued = 0;
        error_count = 0;
        cycle_count = 0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        pix_in.valid  = 1'b0;
        pix_in.data   = '0;
        pix_out.ready = 1'b0;
        coef_rows[0] = '0;
        coef_rows[1] = ic3_pkg::REG_W'(256);
        coef_rows[2] = '0;
        width_reg  = ic3_pkg::DIM_W'(1024);
        height_reg = ic3_pkg::DIM_W'(1024);
        rgb_reg    = 1'b0;
        foreach (window[i]) window[i] = '0;
        foreach (row_store_a[i]) row_store_a[i] = '0;
        foreach (row_store_b[i]) row_store_b[i] = '0;
        restart_frame();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: the reset kernel on a small grey frame with an early
        // drain, then an RGB frame with extreme coefficients.
        set_geometry(3, 2, 1'b0);
        stream_items.push_back(drain_tick());
        queue_frame(3, 2, 6, 1'b0, queued);
        write_reg(ic3_pkg::REG_COEF_TOP, {16'h8000, 16'h7FFF, 16'hFFFF});
        write_reg(ic3_pkg::REG_COEF_MID, {16'h0100, 16'h7FFF, 16'h8000});
        write_reg(ic3_pkg::REG_COEF_BOT, {16'h7FFF, 16'h8000, 16'h0001});
        set_geometry(2, 2, 1'b1);
        stream_items.push_back('{kind: 1'b0, red: 8'hFF, green: 8'h00, blue: 8'hFF});
        stream_items.push_back('{kind: 1'b0, red: 8'h00, green: 8'hFF, blue: 8'h00});
        stream_items.push_back('{kind: 1'b0, red: 8'hFF, green: 8'hFF, blue: 8'hFF});
        stream_items.push_back('{kind: 1'b0, red: 8'h00, green: 8'h00, blue: 8'h00});
        // A surplus pixel stands in for one of the three drain ticks.
        stream_items.push_back(random_pixel());
        stream_items.push_back(drain_tick());
        stream_items.push_back(drain_tick());
        // Width and height of zero behave as one: a single pixel frame.
        set_geometry(0, 0, 1'b0);
        queue_frame(1, 1, 1, 1'b0, queued);

        // Geometry shapes: a wide pair of rows and a single tall column.
        set_kernel();
        set_geometry(40, 2, 1'b1);
        queue_frame(40, 2, 80, 1'b0, queued);
        set_kernel();
        set_geometry(1, 40, 1'b1);
        queue_frame(1, 40, 40, 1'b0, queued);
        // A frame cut off halfway; the geometry write restarts it.
        set_geometry(5, 4, 1'b1);
        queue_frame(5, 4, 11, 1'b0, queued);

        // Random frames, mostly small, with noise items mixed in.
        while (queued < 700) begin
            if ($urandom_range(0, 2) == 0) set_kernel();
            w = $urandom_range(1, 9);
            h = $urandom_range(1, 6);
            set_geometry(w, h, 1'($urandom_range(0, 1)));
            queue_frame(w, h, w * h, 1'b1, queued);
        end

        wait_idle();
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/ic3_pkg.sv
sv/ic3_if.sv
sv/ic3_in_t.sv
sv/ic3_div.sv
sv/ic3_core.sv
sv/ic3_lines.sv
sv/image_convolution_3x3_top.sv
tb/tb_top.sv
